/* rtl/core/eci_pkg.sv */
// Easing curve interpolator package: Q1.16 constants, curve selector codes
// and configuration register indexes. No dependencies.
package eci_pkg;

    // Q1.16 progress value, 0 .. 1.0 inclusive
    typedef logic [16:0] t_q16;

    localparam t_q16        Q_ONE     = 17'd65536;
    localparam logic [17:0] SMOOTH_K3 = 18'd196608;

    // Curve selector codes; unused codes fall back to linear
    localparam logic [2:0] SEL_LINEAR  = 3'd0;
    localparam logic [2:0] SEL_SMOOTH1 = 3'd1;
    localparam logic [2:0] SEL_SMOOTH2 = 3'd2;
    localparam logic [2:0] SEL_SMOOTH3 = 3'd3;
    localparam logic [2:0] SEL_ACCEL   = 3'd4;
    localparam logic [2:0] SEL_DECEL   = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_END   = 2'd1;
    localparam logic [1:0] REG_NUM   = 2'd2;

endpackage

/* rtl/core/easing_curve_interpolator_unit.sv */
// Easing curve interpolator top level: pipelined divider, smoothstep and
// power stages, blend and saturation. Depends on eci_pkg.
//
//  channel | direction | handshake             | payload
//  input   | in        | i_valid / o_stall     | i_req_type, i_step_index, i_curve_power
//  output  | out       | o_valid / i_stall     | o_value
//  config  | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One beat enters per cycle unless the pipeline is stalled. Stages: 17 divider
// stages (one quotient bit per stage after the first), 10 smoothstep stages,
// POWER_MAX + 1 power stages and 3 blend/output stages.
// Reset (synchronous, active low) clears the valid bits and start/end registers, sets num to 1.
// A stalled output freezes the whole pipeline; o_stall follows it.
module easing_curve_interpolator_unit
    import eci_pkg::*;
#(
    parameter int VALUE_BITS = 16,
    parameter int POWER_MAX  = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [2:0]            i_req_type,
    input  logic [15:0]           i_step_index,
    input  logic [3:0]            i_curve_power,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [VALUE_BITS-1:0] o_value,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [(VALUE_BITS > 16 ? VALUE_BITS : 16)-1:0] i_cfg_data
);

    localparam int PW  = (POWER_MAX > 1) ? $clog2(POWER_MAX + 1) : 1;
    localparam int PB  = VALUE_BITS + 18;
    localparam int NB  = PB + 1;
    localparam int DIV_STEPS = 16;
    localparam int SM_STAGES = 9;
    localparam longint SAT_HI = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
    localparam longint SAT_LO = -(64'sd1 <<< (VALUE_BITS - 1));

    typedef struct packed {
        logic [2:0]    sel;
        logic [PW-1:0] pw;
        logic          past;
        logic [15:0]   rem;
        logic [15:0]   quo;
    } t_div;

    typedef struct packed {
        logic [2:0]    sel;
        logic [PW-1:0] pw;
        t_q16          x;
        logic [32:0]   sq;
        logic [17:0]   lin;
        logic [34:0]   ph;
        logic [33:0]   pl;
    } t_sm;

    typedef struct packed {
        logic [2:0]    sel;
        logic [PW-1:0] pw;
        t_q16          v;
        t_q16          px;
        t_q16          r;
    } t_pwr;

    logic                         en;
    logic signed [VALUE_BITS-1:0] r_start;
    logic signed [VALUE_BITS-1:0] r_end;
    logic [15:0]                  r_num;

    t_div r_div     [0:DIV_STEPS];
    logic r_div_vld [0:DIV_STEPS];
    t_sm  r_sm      [0:SM_STAGES];
    logic r_sm_vld  [0:SM_STAGES];
    t_pwr r_pw      [0:POWER_MAX];
    logic r_pw_vld  [0:POWER_MAX];

    logic signed [PB-1:0]         r_pe, r_ps;
    logic                         r_bl1_vld;
    logic signed [NB-1:0]         r_n;
    logic                         r_bl2_vld;
    logic [VALUE_BITS-1:0]        r_out;
    logic                         r_out_vld;

    // Advance everything unless the output holds a beat that is stalled
    assign en          = !(r_out_vld && i_stall);
    assign o_stall     = !en;
    assign o_valid     = r_out_vld;
    assign o_value     = r_out;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_end   <= '0;
            r_num   <= 16'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_START: r_start <= i_cfg_data[VALUE_BITS-1:0];
                REG_END:   r_end   <= i_cfg_data[VALUE_BITS-1:0];
                REG_NUM:   r_num   <= i_cfg_data[15:0];
                default:   ;
            endcase
        end
    end

    // Capture the input beat, saturate the exponent, flag a step past the end
    t_div n_div0;
    always_comb begin
        n_div0.sel  = i_req_type;
        n_div0.pw   = (32'(i_curve_power) > POWER_MAX) ? PW'(POWER_MAX) : PW'(i_curve_power);
        n_div0.past = (i_step_index >= r_num);
        n_div0.rem  = i_step_index;
        n_div0.quo  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_vld[0] <= 1'b0;
        end else if (en) begin
            r_div_vld[0] <= i_valid;
        end
        if (en) begin
            r_div[0] <= n_div0;
        end
    end

    // Restoring divider, one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [16:0] rem2;
        logic        ge;
        t_div        n_div;
        always_comb begin
            rem2  = {r_div[k].rem, 1'b0};
            ge    = (rem2 >= {1'b0, r_num});
            n_div = r_div[k];
            n_div.rem = ge ? 16'(rem2 - {1'b0, r_num}) : rem2[15:0];
            n_div.quo = {r_div[k].quo[14:0], ge};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div_vld[k+1] <= 1'b0;
            end else if (en) begin
                r_div_vld[k+1] <= r_div_vld[k];
            end
            if (en) begin
                r_div[k+1] <= n_div;
            end
        end
    end

    // Form progress, clamped to 1.0 past the end
    t_sm n_sm0;
    always_comb begin
        n_sm0     = '0;
        n_sm0.sel = r_div[DIV_STEPS].sel;
        n_sm0.pw  = r_div[DIV_STEPS].pw;
        n_sm0.x   = r_div[DIV_STEPS].past ? Q_ONE : {1'b0, r_div[DIV_STEPS].quo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sm_vld[0] <= 1'b0;
        end else if (en) begin
            r_sm_vld[0] <= r_div_vld[DIV_STEPS];
        end
        if (en) begin
            r_sm[0] <= n_sm0;
        end
    end

    // Three smoothstep units of three stages: square, partial products, sum
    for (genvar j = 1; j <= SM_STAGES; j++) begin : g_sm
        localparam int PHASE = (j - 1) % 3;
        localparam int UNIT  = (j - 1) / 3;
        t_sm         n_sm;
        logic [35:0] acc;
        logic        apply;
        always_comb begin
            n_sm  = r_sm[j-1];
            acc   = '0;
            apply = (r_sm[j-1].sel >= 3'(UNIT + 1)) && (r_sm[j-1].sel <= SEL_SMOOTH3);
            case (PHASE)
                0: begin
                    n_sm.sq  = 33'(r_sm[j-1].x) * 33'(r_sm[j-1].x);
                    n_sm.lin = SMOOTH_K3 - {r_sm[j-1].x, 1'b0};
                end
                1: begin
                    n_sm.ph = 35'(r_sm[j-1].sq[32:16]) * 35'(r_sm[j-1].lin);
                    n_sm.pl = 34'(r_sm[j-1].sq[15:0]) * 34'(r_sm[j-1].lin);
                end
                default: begin
                    acc = 36'(r_sm[j-1].ph) + 36'(r_sm[j-1].pl[33:16]);
                    if (apply) begin
                        n_sm.x = acc[32:16];
                    end
                end
            endcase
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sm_vld[j] <= 1'b0;
            end else if (en) begin
                r_sm_vld[j] <= r_sm_vld[j-1];
            end
            if (en) begin
                r_sm[j] <= n_sm;
            end
        end
    end

    // Set up the power chain: base is v or 1-v, running product starts at 1.0
    t_pwr n_pw0;
    always_comb begin
        n_pw0.sel = r_sm[SM_STAGES].sel;
        n_pw0.pw  = r_sm[SM_STAGES].pw;
        n_pw0.v   = r_sm[SM_STAGES].x;
        n_pw0.px  = (r_sm[SM_STAGES].sel == SEL_DECEL) ? (Q_ONE - r_sm[SM_STAGES].x)
                                                         : r_sm[SM_STAGES].x;
        n_pw0.r   = Q_ONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw_vld[0] <= 1'b0;
        end else if (en) begin
            r_pw_vld[0] <= r_sm_vld[SM_STAGES];
        end
        if (en) begin
            r_pw[0] <= n_pw0;
        end
    end

    // One multiply per stage while the stage index is below the exponent
    for (genvar i = 0; i < POWER_MAX; i++) begin : g_pw
        t_pwr        n_pw;
        logic [33:0] prod;
        always_comb begin
            n_pw = r_pw[i];
            prod = 34'(r_pw[i].r) * 34'(r_pw[i].px);
            if (32'(r_pw[i].pw) > i) begin
                n_pw.r = prod[32:16];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pw_vld[i+1] <= 1'b0;
            end else if (en) begin
                r_pw_vld[i+1] <= r_pw_vld[i];
            end
            if (en) begin
                r_pw[i+1] <= n_pw;
            end
        end
    end

    // Pick the shaped progress and form both blend products
    t_q16                 vf;
    t_q16                 vc;
    logic signed [PB-1:0] n_pe, n_ps;
    always_comb begin
        case (r_pw[POWER_MAX].sel)
            SEL_ACCEL: vf = r_pw[POWER_MAX].r;
            SEL_DECEL: vf = Q_ONE - r_pw[POWER_MAX].r;
            default:   vf = r_pw[POWER_MAX].v;
        endcase
        vc   = Q_ONE - vf;
        n_pe = PB'(r_end) * PB'($signed({1'b0, vf}));
        n_ps = PB'(r_start) * PB'($signed({1'b0, vc}));
    end

    // Sum the products
    logic signed [NB-1:0] n_n;
    assign n_n = NB'(r_pe) + NB'(r_ps);

    // Divide by 1.0 toward zero and saturate
    logic signed [NB-1:0]  adj, q;
    logic [VALUE_BITS-1:0] n_out;
    always_comb begin
        adj = (r_n < 0) ? (r_n + NB'(65535)) : r_n;
        q   = adj >>> 16;
        if (q > NB'(SAT_HI)) begin
            n_out = VALUE_BITS'(SAT_HI);
        end else if (q < NB'(SAT_LO)) begin
            n_out = VALUE_BITS'(SAT_LO);
        end else begin
            n_out = q[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bl1_vld <= 1'b0;
            r_bl2_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_bl1_vld <= r_pw_vld[POWER_MAX];
            r_bl2_vld <= r_bl1_vld;
            r_out_vld <= r_bl2_vld;
        end
        if (en) begin
            r_pe  <= n_pe;
            r_ps  <= n_ps;
            r_n   <= n_n;
            r_out <= n_out;
        end
    end

endmodule

/* tb/sv/tb_easing_curve_interpolator_unit.sv */
// Testbench for easing_curve_interpolator_unit: directed and random beats,
// each value checked against a built-in Q1.16 easing predictor.
// Depends on eci_pkg and the RTL top level only.
module tb_easing_curve_interpolator_unit;
    import eci_pkg::*;

    localparam int VALUE_BITS = 16;
    localparam int POWER_MAX  = 15;
    localparam int LATENCY    = 31 + POWER_MAX;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] step_index;
        logic [3:0]  curve_power;
    } t_req;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [2:0]            i_req_type = '0;
    logic [15:0]           i_step_index = '0;
    logic [3:0]            i_curve_power = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [VALUE_BITS-1:0] o_value;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index = '0;
    logic [15:0]           i_cfg_data = '0;

    easing_curve_interpolator_unit #(
        .VALUE_BITS(VALUE_BITS),
        .POWER_MAX (POWER_MAX)
    ) u_top (.*);

    always #6 i_clk = ~i_clk;

    // Predictor copy of the registers
    logic signed [15:0] cur_start = 0;
    logic signed [15:0] cur_end   = 0;
    logic [15:0]        cur_num   = 1;

    t_req               pending_reqs[$];
    logic [15:0]        expected_values[$];
    int                 errors = 0;
    int                 n_checked = 0;
    bit                 send_gate = 1'b1;   // cleared to pause the sender
    bit                 hold_long = 1'b0;   // request a long receiver hold-off
    bit                 stim_done = 1'b0;
    bit                 in_taken = 1'b0;    // input beat accepted at the last rising edge
    int                 idle_cycles = 0;

    function automatic logic [16:0] smooth_q16(input logic [16:0] v);
        logic [63:0] sq;
        logic [63:0] lin;
        sq  = 64'(v) * 64'(v);
        lin = 64'(SMOOTH_K3) - 2 * 64'(v);
        return 17'((sq * lin) >> 32);
    endfunction

    function automatic logic [16:0] pow_q16(input logic [16:0] x, input int p);
        logic [63:0] r;
        r = 64'(Q_ONE);
        for (int k = 0; k < p; k++) r = (r * 64'(x)) >> 16;
        return 17'(r);
    endfunction

    function automatic logic [15:0] eased_value(input t_req rq);
        logic [16:0]    v;
        int             p;
        longint signed  n;
        longint signed  q;
        p = (rq.curve_power > POWER_MAX) ? POWER_MAX : int'(rq.curve_power);
        if (rq.step_index >= cur_num) v = Q_ONE;
        else v = 17'((64'(rq.step_index) << 16) / 64'(cur_num));
        case (rq.req_type)
            SEL_SMOOTH1: v = smooth_q16(v);
            SEL_SMOOTH2: v = smooth_q16(smooth_q16(v));
            SEL_SMOOTH3: v = smooth_q16(smooth_q16(smooth_q16(v)));
            SEL_ACCEL:   v = pow_q16(v, p);
            SEL_DECEL:   v = Q_ONE - pow_q16(Q_ONE - v, p);
            default:     ;
        endcase
        n = longint'(cur_end) * longint'(v) + longint'(cur_start) * longint'(Q_ONE - v);
        q = n / 65536;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return 16'(q);
    endfunction

    // Record each input beat accepted at this edge
    always @(posedge i_clk) begin
        in_taken = i_valid && !o_stall;
        if (in_taken) begin
            expected_values.push_back(eased_value({i_req_type, i_step_index, i_curve_power}));
        end
    end

    // Driver: bursts with random gaps; hold the payload while stalled
    int gap_left = 0;
    int burst_left = 0;
    always @(negedge i_clk) begin
        if (!i_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (send_gate && i_rst_n && pending_reqs.size() > 0) begin
                t_req rq;
                rq = pending_reqs.pop_front();
                i_valid       <= 1'b1;
                i_req_type    <= rq.req_type;
                i_step_index  <= rq.step_index;
                i_curve_power <= rq.curve_power;
                if (burst_left > 0) burst_left--;
                else begin
                    burst_left = $urandom_range(0, 20);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, with an occasional long hold-off
    int stall_phase = 0;
    int hold_left = 0;
    always @(negedge i_clk) begin
        stall_phase++;
        if (hold_long && hold_left == 0) begin
            hold_left = 300;
            hold_long = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if ((stall_phase / 200) % 3 == 0) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    // Monitor: compare each beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_values.size() == 0) begin
                $display("%0t: unexpected value beat, actual %0d", $time,
                         $signed(o_value));
                errors++;
            end else begin
                logic [15:0] exp_v;
                exp_v = expected_values.pop_front();
                if (exp_v !== o_value) begin
                    $display("%0t: value mismatch, expected %0d actual %0d", $time,
                             $signed(exp_v), $signed(o_value));
                    errors++;
                end
                n_checked++;
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || stim_done ||
            pending_reqs.size() == 0 && expected_values.size() == 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || i_valid || expected_values.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_START: cur_start = data;
            REG_END:   cur_end   = data;
            REG_NUM:   cur_num   = data;
            default:   ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [15:0] s, input logic [15:0] e,
                            input logic [15:0] num);
        write_reg(REG_START, s);
        write_reg(REG_END, e);
        write_reg(REG_NUM, num);
    endtask

    function automatic t_req rand_req(input logic [15:0] num);
        t_req rq;
        rq.req_type    = 3'($urandom_range(0, 7));
        rq.curve_power = 4'($urandom);
        case ($urandom_range(0, 3))
            0:       rq.step_index = 16'($urandom);
            1:       rq.step_index = 16'(num + $urandom_range(0, 3));
            default: rq.step_index = 16'($urandom_range(0, num));
        endcase
        return rq;
    endfunction

    initial begin
        t_req rq;
        logic [15:0] num;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every curve, range extremes, clamping and zero num_points
        set_regs(16'h8000, 16'h7FFF, 16'd100);
        for (int t = 0; t < 8; t++) begin
            pending_reqs.push_back('{3'(t), 16'd37, 4'(t * 2 + 1)});
        end
        pending_reqs.push_back('{SEL_LINEAR, 16'd0, 4'd0});
        pending_reqs.push_back('{SEL_LINEAR, 16'd100, 4'd0});
        pending_reqs.push_back('{SEL_SMOOTH1, 16'hFFFF, 4'hF});
        pending_reqs.push_back('{SEL_ACCEL, 16'd0, 4'd0});
        pending_reqs.push_back('{SEL_DECEL, 16'd50, 4'd0});
        pending_reqs.push_back('{SEL_ACCEL, 16'd99, 4'd15});
        pending_reqs.push_back('{SEL_DECEL, 16'd1, 4'd15});
        wait_drained();
        set_regs(16'h7FFF, 16'h8000, 16'd0);
        pending_reqs.push_back('{SEL_LINEAR, 16'd0, 4'd0});
        pending_reqs.push_back('{SEL_DECEL, 16'h5555, 4'hA});
        wait_drained();
        set_regs(16'h0000, 16'hFFFF, 16'hFFFF);
        pending_reqs.push_back('{SEL_SMOOTH3, 16'hFFFE, 4'd5});
        pending_reqs.push_back('{SEL_LINEAR, 16'hAAAA, 4'd5});
        wait_drained();

        // Random phases, each with fresh register settings
        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 4)
                0:       num = 16'($urandom_range(1, 16));
                1:       num = 16'hFFFF;
                2:       num = 16'($urandom_range(0, 3));
                default: num = 16'($urandom);
            endcase
            set_regs(16'($urandom), 16'($urandom), num);
            for (int k = 0; k < 125; k++) begin
                rq = rand_req(num);
                pending_reqs.push_back(rq);
            end
            if (ph == 3) hold_long = 1'b1;
            if (ph == 6) begin
                // Pause the sender until every result is back, then resume
                while (pending_reqs.size() > 60) @(posedge i_clk);
                send_gate = 1'b0;
                while (i_valid || expected_values.size() > 0) @(posedge i_clk);
                send_gate = 1'b1;
            end
            wait_drained();
        end

        stim_done = 1'b1;
        $display("Checked %0d values over 13 register settings, all curves and selectors.",
                 n_checked);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
